// File: sv/epl_pkg.sv
`timescale 1ns / 1ps

package epl_pkg;

  // pool and queue sizes
  localparam int NUM_ENTRIES = 32;
  localparam int NUM_QUEUES  = 8;

  // field widths
  localparam int CMD_W    = 3;
  localparam int QUEUE_W  = 3;
  localparam int ENTRY_W  = 5;
  localparam int STATUS_W = 2;
  localparam int TAG_W    = 4;
  localparam int TOP_W    = $clog2(NUM_ENTRIES + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_HEAD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REM_NAMED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_EMPTY     = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  // owner tags: a queue number, idle or free
  localparam logic [TAG_W-1:0] TAG_IDLE = TAG_W'(NUM_QUEUES);
  localparam logic [TAG_W-1:0] TAG_FREE = TAG_W'(NUM_QUEUES + 1);

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_INSERT,
    OP_REM_HEAD,
    OP_PEEK,
    OP_REM_NAMED,
    OP_EMPTY,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               q_ok;
    logic [QUEUE_W-1:0] queue_id;
    logic [ENTRY_W-1:0] entry_id;
  } op_t;

endpackage

// File: sv/epl_req_if.sv
`timescale 1ns / 1ps

interface epl_req_if;
  logic                        valid;
  logic                        ready;
  logic [epl_pkg::CMD_W-1:0]   cmd;
  logic [epl_pkg::QUEUE_W-1:0] queue_id;
  logic [epl_pkg::ENTRY_W-1:0] entry_id;

  modport source (output valid, output cmd, output queue_id, output entry_id, input ready);
  modport sink   (input valid, input cmd, input queue_id, input entry_id, output ready);
endinterface

// File: sv/epl_rsp_if.sv
`timescale 1ns / 1ps

interface epl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [epl_pkg::STATUS_W-1:0] status;
  logic [epl_pkg::ENTRY_W-1:0]  result_entry;
  logic                         queue_empty;

  modport source (output valid, output status, output result_entry, output queue_empty,
                  input ready);
  modport sink   (input valid, input status, input result_entry, input queue_empty,
                  output ready);
endinterface

// File: sv/entry_pool_with_linked_queues.sv
`timescale 1ns / 1ps

// Entry pool with linked queues.
// Request channel req_i carries a command word (cmd, queue_id, entry_id):
// alloc, free, insert at tail, remove head, peek head, remove named entry,
// and empty test. Every command gives exactly one response word on rsp_o
// (status, result_entry, queue_empty), in command order.
// A request is taken when valid and ready are both high. Accepted commands
// wait in a two-word queue; the back end takes each through a fetch state
// that reads the link tables, owner tags and free stack, then an execute
// state that updates them and loads the response register. The back end
// takes no new command until it has done the read-then-write pass over the
// shared link tables for the last one and its response register is free.
// After reset all 32 entries sit on the free stack (highest index on top),
// every entry is tagged free and all 8 queues are empty; no clearing pass.
// The response register holds its word while rsp_o.ready is low; the back
// end stops once it is full, and req_i.ready drops when the queue fills.
module entry_pool_with_linked_queues (
  input  logic       clk_i,
  input  logic       rst_ni,
  epl_req_if.sink    req_i,
  epl_rsp_if.source  rsp_o
);

  localparam int OP_W = $bits(epl_pkg::op_t);

  logic            push;
  logic            full;
  logic            empty;
  logic            pop;
  epl_pkg::op_t    front_op;
  epl_pkg::op_t    back_op;
  logic [OP_W-1:0] fifo_rd;

  // decode and classify
  epl_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .op_o   (front_op)
  );

  // command queue between front and back
  epl_fifo #(
    .WIDTH (OP_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_op),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (fifo_rd),
    .empty_o (empty)
  );

  assign back_op = epl_pkg::op_t'(fifo_rd);

  // execution against the pool and link tables
  epl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (!empty),
    .op_i         (back_op),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

endmodule

// File: sv/epl_fifo.sv
`timescale 1ns / 1ps

module epl_fifo #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update, pointers wrap at DEPTH
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/epl_front.sv
`timescale 1ns / 1ps

module epl_front (
  epl_req_if.sink        req_i,
  input  logic           full_i,
  output logic           push_o,
  output epl_pkg::op_t   op_o
);

  logic q_ok;
  logic e_ok;

  // range checks on queue and entry
  assign q_ok = (epl_pkg::QUEUE_W + 1)'(req_i.queue_id) <
                (epl_pkg::QUEUE_W + 1)'(epl_pkg::NUM_QUEUES);
  assign e_ok = (epl_pkg::ENTRY_W + 1)'(req_i.entry_id) <
                (epl_pkg::ENTRY_W + 1)'(epl_pkg::NUM_ENTRIES);

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  // classify the command word; illegal requests are marked for rejection here
  always_comb begin
    op_o.q_ok     = q_ok;
    op_o.queue_id = req_i.queue_id;
    op_o.entry_id = req_i.entry_id;
    case (req_i.cmd)
      epl_pkg::CMD_ALLOC:     op_o.op = epl_pkg::OP_ALLOC;
      epl_pkg::CMD_FREE:      op_o.op = e_ok ? epl_pkg::OP_FREE : epl_pkg::OP_REJECT;
      epl_pkg::CMD_INSERT:    op_o.op = (q_ok && e_ok) ? epl_pkg::OP_INSERT
                                                       : epl_pkg::OP_REJECT;
      epl_pkg::CMD_REM_HEAD:  op_o.op = q_ok ? epl_pkg::OP_REM_HEAD : epl_pkg::OP_REJECT;
      epl_pkg::CMD_PEEK:      op_o.op = q_ok ? epl_pkg::OP_PEEK : epl_pkg::OP_REJECT;
      epl_pkg::CMD_REM_NAMED: op_o.op = (q_ok && e_ok) ? epl_pkg::OP_REM_NAMED
                                                       : epl_pkg::OP_REJECT;
      epl_pkg::CMD_EMPTY:     op_o.op = q_ok ? epl_pkg::OP_EMPTY : epl_pkg::OP_REJECT;
      default:                op_o.op = epl_pkg::OP_REJECT;
    endcase
  end

endmodule

// File: sv/epl_back.sv
`timescale 1ns / 1ps

module epl_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fifo_valid_i,
  input  epl_pkg::op_t op_i,
  output logic         pop_o,
  epl_rsp_if.source    rsp_o
);

  localparam int EW = epl_pkg::ENTRY_W;
  localparam int TW = epl_pkg::TAG_W;
  localparam int PW = epl_pkg::TOP_W;
  localparam int NE = epl_pkg::NUM_ENTRIES;
  localparam int NQ = epl_pkg::NUM_QUEUES;

  localparam logic ST_FETCH = 1'b0;
  localparam logic ST_EXEC  = 1'b1;

  // sequencer and operation being executed
  logic          state_q, state_d;
  epl_pkg::op_t  op_q;
  logic          exec;

  // values read in the fetch cycle
  logic          ne_r_q;
  logic [EW-1:0] first_r_q, last_r_q, tgt_r_q, next_r_q, prev_r_q, stack_r_q;
  logic [TW-1:0] owner_r_q;
  logic          head_op;
  logic [EW-1:0] tgt;

  // pool state
  logic [PW-1:0]   top_q;
  logic [EW-1:0]   stack_q [NE];
  logic [TW-1:0]   owner_q [NE];
  logic [EW-1:0]   next_q  [NE];
  logic [EW-1:0]   prev_q  [NE];
  logic [EW-1:0]   first_q [NQ];
  logic [EW-1:0]   last_q  [NQ];
  logic [NQ-1:0]   ne_q;

  // update controls
  logic                         top_we;
  logic [PW-1:0]                top_wd;
  logic                         stack_we;
  logic                         owner_we;
  logic [EW-1:0]                owner_wa;
  logic [TW-1:0]                owner_wd;
  logic                         nxt_we_a, nxt_we_b;
  logic [EW-1:0]                nxt_wa_a, nxt_wd_a;
  logic                         prv_we;
  logic [EW-1:0]                prv_wa, prv_wd;
  logic                         first_we, last_we, ne_we, ne_wd;
  logic [EW-1:0]                first_wd, last_wd;
  logic                         unl_en;
  logic [EW-1:0]                unl_x;
  logic                         is_first, is_last;
  logic                         ne_after;
  logic [epl_pkg::STATUS_W-1:0] st;
  logic [EW-1:0]                res;

  // response register
  logic                         out_valid_q;
  logic [epl_pkg::STATUS_W-1:0] out_status_q;
  logic [EW-1:0]                out_entry_q;
  logic                         out_empty_q;

  assign exec  = (state_q == ST_EXEC);
  assign pop_o = (state_q == ST_FETCH) && fifo_valid_i && (!out_valid_q || rsp_o.ready);

  // fetch: pick the entry the command works on and read its links
  assign head_op = (op_i.op == epl_pkg::OP_REM_HEAD) || (op_i.op == epl_pkg::OP_PEEK);
  assign tgt     = head_op ? first_q[op_i.queue_id] : op_i.entry_id;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q      <= op_i;
      ne_r_q    <= ne_q[op_i.queue_id];
      first_r_q <= first_q[op_i.queue_id];
      last_r_q  <= last_q[op_i.queue_id];
      tgt_r_q   <= tgt;
      next_r_q  <= next_q[tgt];
      prev_r_q  <= prev_q[tgt];
      owner_r_q <= owner_q[op_i.entry_id];
      stack_r_q <= stack_q[EW'(top_q - PW'(1))];
    end
  end

  // sequencer: fetch then execute
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FETCH: if (pop_o) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_FETCH;
      default:  state_d = ST_FETCH;
    endcase
  end

  // execute: work out status, result and table updates
  always_comb begin
    st       = epl_pkg::ST_OK;
    res      = '0;
    top_we   = 1'b0;
    top_wd   = top_q;
    stack_we = 1'b0;
    owner_we = 1'b0;
    owner_wa = op_q.entry_id;
    owner_wd = epl_pkg::TAG_IDLE;
    nxt_we_a = 1'b0;
    nxt_wa_a = last_r_q;
    nxt_wd_a = op_q.entry_id;
    nxt_we_b = 1'b0;
    prv_we   = 1'b0;
    prv_wa   = op_q.entry_id;
    prv_wd   = last_r_q;
    first_we = 1'b0;
    first_wd = op_q.entry_id;
    last_we  = 1'b0;
    last_wd  = op_q.entry_id;
    ne_we    = 1'b0;
    ne_wd    = 1'b0;
    unl_en   = 1'b0;
    unl_x    = op_q.entry_id;
    is_first = 1'b0;
    is_last  = 1'b0;

    case (op_q.op)
      epl_pkg::OP_ALLOC: begin
        if (top_q == '0) begin
          st = epl_pkg::ST_NONE;
        end else begin
          top_we   = 1'b1;
          top_wd   = top_q - PW'(1);
          owner_we = 1'b1;
          owner_wa = stack_r_q;
          owner_wd = epl_pkg::TAG_IDLE;
          res      = stack_r_q;
        end
      end
      epl_pkg::OP_FREE: begin
        if (owner_r_q != epl_pkg::TAG_IDLE || top_q >= PW'(NE)) begin
          st = epl_pkg::ST_REJECT;
        end else begin
          stack_we = 1'b1;
          top_we   = 1'b1;
          top_wd   = top_q + PW'(1);
          owner_we = 1'b1;
          owner_wd = epl_pkg::TAG_FREE;
          res      = op_q.entry_id;
        end
      end
      epl_pkg::OP_INSERT: begin
        if (owner_r_q != epl_pkg::TAG_IDLE) begin
          st = epl_pkg::ST_REJECT;
        end else begin
          // link behind the old tail, or start a fresh list
          prv_we = 1'b1;
          if (ne_r_q) begin
            nxt_we_a = 1'b1;
            prv_wd   = last_r_q;
          end else begin
            first_we = 1'b1;
            prv_wd   = op_q.entry_id;
            ne_we    = 1'b1;
            ne_wd    = 1'b1;
          end
          nxt_we_b = 1'b1;
          last_we  = 1'b1;
          owner_we = 1'b1;
          owner_wd = TW'(op_q.queue_id);
          res      = op_q.entry_id;
        end
      end
      epl_pkg::OP_REM_HEAD, epl_pkg::OP_PEEK: begin
        if (!ne_r_q) begin
          st = epl_pkg::ST_NONE;
        end else begin
          res    = tgt_r_q;
          unl_en = (op_q.op == epl_pkg::OP_REM_HEAD);
          unl_x  = tgt_r_q;
        end
      end
      epl_pkg::OP_REM_NAMED: begin
        if (owner_r_q != TW'(op_q.queue_id)) begin
          st = epl_pkg::ST_NONE;
        end else begin
          res    = op_q.entry_id;
          unl_en = 1'b1;
          unl_x  = op_q.entry_id;
        end
      end
      epl_pkg::OP_EMPTY: begin
        st = epl_pkg::ST_OK;
      end
      default: begin
        st = epl_pkg::ST_REJECT;
      end
    endcase

    // unlink: the entry's owner tag goes idle; only the queue ends or the two neighbors change
    if (unl_en) begin
      is_first = (first_r_q == unl_x);
      is_last  = (last_r_q == unl_x);
      owner_we = 1'b1;
      owner_wa = unl_x;
      owner_wd = epl_pkg::TAG_IDLE;
      if (is_first && is_last) begin
        ne_we = 1'b1;
        ne_wd = 1'b0;
      end else if (is_first) begin
        first_we = 1'b1;
        first_wd = next_r_q;
      end else if (is_last) begin
        last_we = 1'b1;
        last_wd = prev_r_q;
      end else begin
        nxt_we_a = 1'b1;
        nxt_wa_a = prev_r_q;
        nxt_wd_a = next_r_q;
        prv_we   = 1'b1;
        prv_wa   = next_r_q;
        prv_wd   = prev_r_q;
      end
    end

    ne_after = ne_we ? ne_wd : ne_r_q;
  end

  // control state and reset-valued tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FETCH;
      top_q       <= PW'(NE);
      ne_q        <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NE; k++) begin
        stack_q[k] <= EW'(k);
        owner_q[k] <= epl_pkg::TAG_FREE;
      end
    end else begin
      state_q <= state_d;
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (exec && top_we) begin
        top_q <= top_wd;
      end
      if (exec && stack_we) begin
        stack_q[top_q[EW-1:0]] <= op_q.entry_id;
      end
      if (exec && owner_we) begin
        owner_q[owner_wa] <= owner_wd;
      end
      if (exec && ne_we) begin
        ne_q[op_q.queue_id] <= ne_wd;
      end
    end
  end

  // link tables, queue ends and response word, meaningful only where marked valid
  always_ff @(posedge clk_i) begin
    if (exec) begin
      if (nxt_we_a) begin
        next_q[nxt_wa_a] <= nxt_wd_a;
      end
      if (nxt_we_b) begin
        next_q[op_q.entry_id] <= op_q.entry_id;
      end
      if (prv_we) begin
        prev_q[prv_wa] <= prv_wd;
      end
      if (first_we) begin
        first_q[op_q.queue_id] <= first_wd;
      end
      if (last_we) begin
        last_q[op_q.queue_id] <= last_wd;
      end
      out_status_q <= st;
      out_entry_q  <= (st == epl_pkg::ST_OK) ? res : '0;
      out_empty_q  <= !(op_q.q_ok && ne_after);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.result_entry = out_entry_q;
  assign rsp_o.queue_empty  = out_empty_q;

endmodule

// File: sv/epl_checker.sv
`timescale 1ns / 1ps

module epl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [epl_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [epl_pkg::ENTRY_W-1:0]  rsp_result_entry_i,
  input logic                         rsp_queue_empty_i
);

  // a stalled response word stays up
  a_rsp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // and keeps its contents
  a_rsp_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_result_entry_i) && $stable(rsp_queue_empty_i))
    else $error("response changed while stalled");

  // only defined status codes
  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == epl_pkg::ST_OK || rsp_status_i == epl_pkg::ST_NONE ||
                     rsp_status_i == epl_pkg::ST_REJECT))
    else $error("undefined status code");

  // failed commands report entry zero
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != epl_pkg::ST_OK |-> rsp_result_entry_i == '0)
    else $error("nonzero entry on failed command");

endmodule

bind entry_pool_with_linked_queues epl_checker u_epl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_result_entry_i (rsp_o.result_entry),
  .rsp_queue_empty_i  (rsp_o.queue_empty)
);
